@@ hw/rtl/tmad_pkg.sv @@
// Shared types and constants for the task-mapped address decoder.
// No dependencies; imported by task_mapped_address_decoder_top.
package tmad_pkg;

  localparam int MAP_DEPTH    = 512;
  localparam int LOCAL_DEPTH  = 1024;
  localparam int SWITCH_DELAY = 8;

  localparam int MAP_AW   = $clog2(MAP_DEPTH);
  localparam int LOCAL_AW = $clog2(LOCAL_DEPTH);

  // configuration register indexes
  localparam logic [1:0] REG_SWITCH   = 2'd0;
  localparam logic [1:0] REG_KEYBOARD = 2'd1;
  localparam logic [1:0] REG_TRAP_ADR = 2'd2;
  localparam logic [1:0] REG_TRAP_ST  = 2'd3;

  // board register offsets within 0x400..0x403
  localparam logic [1:0] BRD_TRAP_ADR = 2'd0;
  localparam logic [1:0] BRD_KEYBOARD = 2'd1;
  localparam logic [1:0] BRD_TASK     = 2'd2;
  localparam logic [1:0] BRD_TRAP_ST  = 2'd3;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {
    TGT_INTERNAL = 2'd0,
    TGT_BUS      = 2'd1,
    TGT_ROM      = 2'd2
  } target_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNKNOWN_REG = 2'd1,
    ST_MAP_READ    = 2'd2,
    ST_ROM_WRITE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SRC_CONST = 2'd0,
    SRC_LOCAL = 2'd1,
    SRC_FPU   = 2'd2
  } src_t;

endpackage

@@ hw/rtl/task_mapped_address_decoder_top.sv @@
// Task-mapped address decoder: one CPU byte access in, one decoded result out.
// Depends on tmad_pkg. Holds map RAM, local RAM and FPU RAM internally.
//
//   channel   | dir | handshake             | payload
//   s_axis    | in  | tvalid/tready         | tdata: cpu_address, write_value
//             |     |                       | tuser: command, is_fetch
//   m_axis    | out | tvalid/tready         | tdata: read_data, phys_address, bus_write,
//             |     |                       |        bus_data, rom_address
//             |     |                       | tuser: target, status
//   cfg       | in  | cfg_wr_en (no stall)  | cfg_index, cfg_wdata
//
// One word per cycle while m_axis does not stall and no clearing pass runs.
// Decode and state update happen at accept, RAM read data and decode are
// registered, then the result register drives m_axis.
// After rst a clearing pass zeroes all three RAMs, one entry per cycle over
// LOCAL_DEPTH (1024) addresses, with s_axis_tready low. cfg writes are taken.
// A stalled m_axis holds the result; up to one more word is taken meanwhile.
module task_mapped_address_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] cpu_address, [23:16] write_value
  input  logic [1:0]  s_axis_tuser,   // [0] command, [1] is_fetch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] read_data, [31:8] phys_address,
                                      // [32] bus_write, [40:33] bus_data,
                                      // [52:41] rom_address, [55:53] zero
  output logic [3:0]  m_axis_tuser,   // [1:0] target, [3:2] status
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import tmad_pkg::*;

  // configuration
  logic [7:0] switch_value, keyboard_value, trap_address, trap_status;

  // task state
  logic [7:0]  task_register, pending_task;
  logic [3:0]  switch_countdown;
  logic [15:0] last_fetch_address;
  logic        rom_page;

  // clearing pass
  logic                clearing;
  logic [LOCAL_AW-1:0] clr_addr;

  // memories
  logic [7:0] map_ram   [MAP_DEPTH];
  logic [7:0] work_ram  [LOCAL_DEPTH];
  logic [7:0] fpu_ram   [LOCAL_DEPTH];
  logic [7:0] map_q, local_q, fpu_q;

  // input fields
  logic        in_wr, in_fetch, accept;
  logic [15:0] in_addr;
  logic [7:0]  in_val;

  // decode
  logic              cd_step, cd_expire;
  logic [3:0]        cd_dec;
  logic [7:0]        eff_task;
  logic              is_bus, task_wr;
  logic [MAP_AW-1:0] map_entry;
  logic              map_we_item, local_we_item, fpu_we_item;
  src_t              d_src;
  logic [7:0]        d_const;
  target_t           d_target;
  status_t           d_status;
  logic [11:0]       d_rom;

  // RAM write ports
  logic                map_we, local_we, fpu_we;
  logic [MAP_AW-1:0]   map_waddr;
  logic [LOCAL_AW-1:0] lf_waddr;
  logic [7:0]          mem_wdata;

  // stage 1
  logic        s1_valid, s1_adv;
  src_t        s1_src;
  logic [7:0]  s1_const;
  target_t     s1_target;
  status_t     s1_status;
  logic [3:0]  s1_hi;
  logic [11:0] s1_lo;
  logic        s1_bwr;
  logic [7:0]  s1_bdata;
  logic [11:0] s1_rom;

  // result register
  logic        out_valid;
  logic [7:0]  out_rdata;
  target_t     out_target;
  status_t     out_status;
  logic [23:0] out_phys;
  logic        out_bwr;
  logic [7:0]  out_bdata;
  logic [11:0] out_rom;
  logic [7:0]  rdata_next;
  logic [23:0] phys_next;

  assign in_addr  = s_axis_tdata[15:0];
  assign in_val   = s_axis_tdata[23:16];
  assign in_wr    = (s_axis_tuser[0] == CMD_WRITE);
  assign in_fetch = s_axis_tuser[1];

  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !clearing && (!s1_valid || s1_adv);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cd_step   = !in_wr && (switch_countdown != 4'd0) && in_fetch &&
                (last_fetch_address != in_addr);
    cd_dec    = switch_countdown - 4'd1;
    cd_expire = cd_step && (cd_dec == 4'd0);
    eff_task  = cd_expire ? pending_task : task_register;
    is_bus    = (eff_task[3:0] != 4'd0) || (in_addr[15:12] != 4'd0);
    map_entry = {eff_task[3:0], in_addr[15:12], 1'b0};

    d_src         = SRC_CONST;
    d_const       = 8'd0;
    d_target      = TGT_INTERNAL;
    d_status      = ST_OK;
    d_rom         = 12'd0;
    task_wr       = 1'b0;
    map_we_item   = 1'b0;
    local_we_item = 1'b0;
    fpu_we_item   = 1'b0;

    if (is_bus) begin
      d_target = TGT_BUS;
    end else begin
      case (in_addr[11:10])
        2'b00: begin
          if (in_wr) local_we_item = 1'b1;
          else d_src = SRC_LOCAL;
        end
        2'b01: begin
          if (in_addr[9] == 1'b0) begin
            if (in_addr[8:2] != 7'd0) begin
              d_status = ST_UNKNOWN_REG;
            end else if (in_wr) begin
              task_wr = (in_addr[1:0] == BRD_TASK);
            end else begin
              case (in_addr[1:0])
                BRD_TRAP_ADR: d_const = trap_address;
                BRD_KEYBOARD: d_const = keyboard_value;
                BRD_TASK:     d_const = switch_value;
                BRD_TRAP_ST:  d_const = trap_status;
                default:      d_const = 8'd0;
              endcase
            end
          end else begin
            if (in_wr) map_we_item = 1'b1;
            else d_status = ST_MAP_READ;
          end
        end
        2'b10: begin
          if (in_wr) begin
            d_status = ST_ROM_WRITE;
          end else begin
            d_target = TGT_ROM;
            d_rom    = {1'b0, rom_page, in_addr[9:0]};
          end
        end
        default: begin
          if (in_wr) fpu_we_item = 1'b1;
          else d_src = SRC_FPU;
        end
      endcase
    end
  end

  // write ports shared between the clearing pass and item writes
  assign map_we    = clearing || (accept && map_we_item);
  assign local_we  = clearing || (accept && local_we_item);
  assign fpu_we    = clearing || (accept && fpu_we_item);
  assign map_waddr = clearing ? clr_addr[MAP_AW-1:0] : in_addr[MAP_AW-1:0];
  assign lf_waddr  = clearing ? clr_addr : in_addr[LOCAL_AW-1:0];
  assign mem_wdata = clearing ? 8'd0 : in_val;

  always_ff @(posedge clk) begin
    if (map_we) map_ram[map_waddr] <= mem_wdata;
    if (local_we) work_ram[lf_waddr] <= mem_wdata;
    if (fpu_we) fpu_ram[lf_waddr] <= mem_wdata;
    if (accept) begin
      map_q   <= map_ram[map_entry];
      local_q <= work_ram[in_addr[LOCAL_AW-1:0]];
      fpu_q   <= fpu_ram[in_addr[LOCAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LOCAL_AW'(LOCAL_DEPTH - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_value   <= 8'd20;
      keyboard_value <= 8'd0;
      trap_address   <= 8'd0;
      trap_status    <= 8'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SWITCH:   switch_value   <= cfg_wdata;
        REG_KEYBOARD: keyboard_value <= cfg_wdata;
        REG_TRAP_ADR: trap_address   <= cfg_wdata;
        REG_TRAP_ST:  trap_status    <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_register      <= 8'd0;
      pending_task       <= 8'd0;
      switch_countdown   <= 4'd0;
      last_fetch_address <= 16'd0;
      rom_page           <= 1'b0;
    end else if (accept) begin
      task_register <= eff_task;
      if (cd_step) begin
        switch_countdown   <= cd_dec;
        last_fetch_address <= in_addr;
      end
      if (task_wr) begin
        rom_page         <= 1'b1;
        pending_task     <= in_val;
        switch_countdown <= 4'(SWITCH_DELAY);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src    <= d_src;
      s1_const  <= d_const;
      s1_target <= d_target;
      s1_status <= d_status;
      s1_hi     <= is_bus ? eff_task[7:4] : 4'd0;
      s1_lo     <= is_bus ? in_addr[11:0] : 12'd0;
      s1_bwr    <= is_bus && in_wr;
      s1_bdata  <= (is_bus && in_wr) ? in_val : 8'd0;
      s1_rom    <= d_rom;
    end
  end

  always_comb begin
    case (s1_src)
      SRC_LOCAL: rdata_next = local_q;
      SRC_FPU:   rdata_next = fpu_q;
      default:   rdata_next = s1_const;
    endcase
    phys_next = {s1_hi, (s1_target == TGT_BUS) ? map_q : 8'd0, s1_lo};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rdata  <= rdata_next;
      out_target <= s1_target;
      out_status <= s1_status;
      out_phys   <= phys_next;
      out_bwr    <= s1_bwr;
      out_bdata  <= s1_bdata;
      out_rom    <= s1_rom;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'd0, out_rom, out_bdata, out_bwr, out_phys, out_rdata};
  assign m_axis_tuser  = {out_status, out_target};

`ifndef SYNTHESIS
  a_cd_range: assert property (@(posedge clk) disable iff (rst)
    switch_countdown <= 4'(SWITCH_DELAY))
    else $error("switch countdown above its start value");

  a_cd_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && switch_countdown != $past(switch_countdown) |->
      switch_countdown == $past(switch_countdown) - 4'd1 ||
      switch_countdown == 4'(SWITCH_DELAY))
    else $error("switch countdown moved by more than one step");

  a_task_switch: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && task_register != $past(task_register) |->
      switch_countdown == 4'd0 && $past(switch_countdown) == 4'd1)
    else $error("task register changed outside countdown expiry");

  a_rom_page: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(rom_page) |-> rom_page)
    else $error("eprom page fell back");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept && !s1_valid)
    else $error("word taken during RAM clearing pass");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("stage 1 word lost while stalled");
`endif

endmodule
